// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define EQD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("eqd assertion failed");

// Checked at every clock edge, reset included.
`define EQD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("eqd assertion failed during or after reset");

`endif

// File: hw/rtl/eqd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqd_pkg
// Shared constants, types and the arctangent table of the Euler to
// quaternion unit.
// ----------------------------------------------------------------------------
package eqd_pkg;

  localparam int TRIG_ITERATIONS_DEF = 16;
  localparam int OUT_FRAC_BITS_DEF   = 14;

  localparam int ANGLE_W  = 17;
  localparam int QUAT_W   = 16;
  localparam int TRIG_W   = 32;  // sine and cosine, Q30
  localparam int CORDIC_W = 34;  // CORDIC x, y and z
  localparam int COMP_W   = 34;  // unnormalized quaternion components, Q30
  localparam int SUM_W    = 64;
  localparam int NORM_W   = 32;
  localparam int ISQRT_STAGES = 32;
  localparam int COMBINE_STAGES = 5;

  localparam int HALF_CIRCLE_UNITS = 92160;
  localparam int QUADRANT_UNITS    = 23040;
  localparam int HALF_DEG_UNIT_Q30 = 73204;
  localparam int CORDIC_START_Q30  = 652032874;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } sincos_t;

  // atan(2^-i) in Q30.
  function automatic logic [30:0] atan_q30(input int i);
    logic [30:0] v;
    case (i)
      0:  v = 31'd843314857;
      1:  v = 31'd497837829;
      2:  v = 31'd263043837;
      3:  v = 31'd133525159;
      4:  v = 31'd67021687;
      5:  v = 31'd33543516;
      6:  v = 31'd16775851;
      7:  v = 31'd8388437;
      8:  v = 31'd4194283;
      9:  v = 31'd2097149;
      10: v = 31'd1048575;
      11: v = 31'd524288;
      12: v = 31'd262144;
      13: v = 31'd131072;
      14: v = 31'd65536;
      15: v = 31'd32768;
      16: v = 31'd16384;
      17: v = 31'd8192;
      18: v = 31'd4096;
      19: v = 31'd2048;
      20: v = 31'd1024;
      21: v = 31'd512;
      22: v = 31'd256;
      23: v = 31'd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/eqd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqd_if
// Valid/ready channels of the Euler to quaternion unit: three angles in,
// four quaternion components out.
// ----------------------------------------------------------------------------
interface eqd_angle_if;
  logic valid;
  logic ready;
  logic signed [eqd_pkg::ANGLE_W-1:0] angle_x;
  logic signed [eqd_pkg::ANGLE_W-1:0] angle_y;
  logic signed [eqd_pkg::ANGLE_W-1:0] angle_z;

  modport source(output valid, output angle_x, output angle_y, output angle_z,
                 input ready);
  modport sink(input valid, input angle_x, input angle_y, input angle_z,
               output ready);
endinterface

interface eqd_quat_if;
  logic valid;
  logic ready;
  logic signed [eqd_pkg::QUAT_W-1:0] quat_x;
  logic signed [eqd_pkg::QUAT_W-1:0] quat_y;
  logic signed [eqd_pkg::QUAT_W-1:0] quat_z;
  logic signed [eqd_pkg::QUAT_W-1:0] quat_w;

  modport source(output valid, output quat_x, output quat_y, output quat_z,
                 output quat_w, input ready);
  modport sink(input valid, input quat_x, input quat_y, input quat_z,
               input quat_w, output ready);
endinterface

// File: hw/rtl/euler_degrees_to_quaternion_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_degrees_to_quaternion_unit
// Converts XYZ Euler angles in 1/128 degree to a normalized quaternion.
// ----------------------------------------------------------------------------
// Usage: angles carries three 17-bit signed angles per item; quat carries
// the four normalized components, 2^OUT_FRAC_BITS standing for 1.0.
// Every input item gives exactly one result item, in order.
// Three CORDIC lanes, the product and sum-of-squares stages, a 32-stage
// square root and four restoring divider lanes make up the pipeline.
// Throughput is one item per cycle while quat is not stalled; the whole
// pipeline advances together, and the divider's last stage is the
// output register.
// When quat is stalled with a result waiting, the pipeline and angles.ready
// hold until the result is taken; while the output register is empty,
// angles.ready is high and the pipeline keeps advancing.
// Reset clears the valid bits of all stages; the data path is not reset.
// ----------------------------------------------------------------------------
module euler_degrees_to_quaternion_unit #(
  parameter int TRIG_ITERATIONS = eqd_pkg::TRIG_ITERATIONS_DEF,
  parameter int OUT_FRAC_BITS   = eqd_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  eqd_angle_if.sink         angles,
  eqd_quat_if.source        quat
);

  localparam int LAT = TRIG_ITERATIONS + 3 + eqd_pkg::COMBINE_STAGES +
                       eqd_pkg::ISQRT_STAGES + OUT_FRAC_BITS + 3;
  localparam logic [eqd_pkg::QUAT_W-1:0] ONE_OUT =
      eqd_pkg::QUAT_W'(64'(1) << OUT_FRAC_BITS);

  logic en;
  logic [LAT-1:0] vld;

  eqd_pkg::sincos_t scx, scy, scz;
  logic signed [eqd_pkg::COMP_W-1:0] comp [0:3];
  logic signed [eqd_pkg::COMP_W-1:0] comp_n [0:3];
  logic [eqd_pkg::SUM_W-1:0]  sum;
  logic [eqd_pkg::NORM_W-1:0] norm;
  logic [eqd_pkg::QUAT_W-1:0] qo [0:3];
  logic zero;

  assign en = !vld[LAT-1] || quat.ready;
  assign angles.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], angles.valid};
    end
  end

  eqd_cordic_lane #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_lane_x (
    .clk(clk), .en(en), .angle(angles.angle_x), .sc(scx));
  eqd_cordic_lane #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_lane_y (
    .clk(clk), .en(en), .angle(angles.angle_y), .sc(scy));
  eqd_cordic_lane #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_lane_z (
    .clk(clk), .en(en), .angle(angles.angle_z), .sc(scz));

  eqd_combine u_combine (
    .clk(clk), .en(en), .scx(scx), .scy(scy), .scz(scz),
    .comp(comp), .sum(sum));

  eqd_isqrt u_isqrt (
    .clk(clk), .en(en), .comp_in(comp), .sum(sum),
    .comp_out(comp_n), .norm(norm));

  eqd_div_lane #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_0 (
    .clk(clk), .en(en), .comp(comp_n[0]), .norm(norm), .quat(qo[0]), .zero(zero));
  eqd_div_lane #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_1 (
    .clk(clk), .en(en), .comp(comp_n[1]), .norm(norm), .quat(qo[1]), .zero());
  eqd_div_lane #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_2 (
    .clk(clk), .en(en), .comp(comp_n[2]), .norm(norm), .quat(qo[2]), .zero());
  eqd_div_lane #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_3 (
    .clk(clk), .en(en), .comp(comp_n[3]), .norm(norm), .quat(qo[3]), .zero());

  // A zero norm gives the identity rotation.
  assign quat.valid  = vld[LAT-1];
  assign quat.quat_x = zero ? '0 : qo[0];
  assign quat.quat_y = zero ? '0 : qo[1];
  assign quat.quat_z = zero ? '0 : qo[2];
  assign quat.quat_w = zero ? ONE_OUT : qo[3];

endmodule

// File: hw/rtl/eqd_cordic_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqd_cordic_lane
// Sine and cosine of half an angle: quadrant reduction, radian conversion
// and a pipelined circular CORDIC, one iteration per stage.
// ----------------------------------------------------------------------------
module eqd_cordic_lane #(
  parameter int TRIG_ITERATIONS = eqd_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [eqd_pkg::ANGLE_W-1:0]  angle,
  output eqd_pkg::sincos_t                    sc
);

  localparam int CW = eqd_pkg::CORDIC_W;

  logic signed [eqd_pkg::ANGLE_W:0] wrapped;
  logic [eqd_pkg::ANGLE_W-1:0]      p;
  eqd_pkg::quad_t                   quad_a;
  logic [14:0]                      rem_a;
  eqd_pkg::quad_t                   quad_c;
  logic [14:0]                      rem_c;

  logic signed [CW-1:0] x_r [0:TRIG_ITERATIONS];
  logic signed [CW-1:0] y_r [0:TRIG_ITERATIONS];
  logic signed [CW-1:0] z_r [0:TRIG_ITERATIONS];
  eqd_pkg::quad_t       quad_r [0:TRIG_ITERATIONS];

  // The half angle in 1/256 degree is the raw input; wrap it into one turn.
  always_comb begin
    wrapped = (eqd_pkg::ANGLE_W+1)'(angle) +
              (eqd_pkg::ANGLE_W+1)'(eqd_pkg::HALF_CIRCLE_UNITS);
    p = angle[eqd_pkg::ANGLE_W-1] ? wrapped[eqd_pkg::ANGLE_W-1:0]
                                  : angle[eqd_pkg::ANGLE_W-1:0];
    if (p >= eqd_pkg::ANGLE_W'(3 * eqd_pkg::QUADRANT_UNITS)) begin
      quad_c = eqd_pkg::QUAD_3;
      rem_c  = 15'(p - eqd_pkg::ANGLE_W'(3 * eqd_pkg::QUADRANT_UNITS));
    end else if (p >= eqd_pkg::ANGLE_W'(2 * eqd_pkg::QUADRANT_UNITS)) begin
      quad_c = eqd_pkg::QUAD_2;
      rem_c  = 15'(p - eqd_pkg::ANGLE_W'(2 * eqd_pkg::QUADRANT_UNITS));
    end else if (p >= eqd_pkg::ANGLE_W'(eqd_pkg::QUADRANT_UNITS)) begin
      quad_c = eqd_pkg::QUAD_1;
      rem_c  = 15'(p - eqd_pkg::ANGLE_W'(eqd_pkg::QUADRANT_UNITS));
    end else begin
      quad_c = eqd_pkg::QUAD_0;
      rem_c  = 15'(p);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad_a    <= quad_c;
      rem_a     <= rem_c;
      quad_r[0] <= quad_a;
      x_r[0]    <= CW'(eqd_pkg::CORDIC_START_Q30);
      y_r[0]    <= '0;
      z_r[0]    <= CW'(rem_a) * CW'(eqd_pkg::HALF_DEG_UNIT_Q30);
    end
  end

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_iter
    localparam logic signed [CW-1:0] ATAN = CW'(eqd_pkg::atan_q30(i));
    always_ff @(posedge clk) begin
      if (en) begin
        quad_r[i+1] <= quad_r[i];
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (quad_r[TRIG_ITERATIONS])
        eqd_pkg::QUAD_0: begin
          sc.s <= eqd_pkg::TRIG_W'(y_r[TRIG_ITERATIONS]);
          sc.c <= eqd_pkg::TRIG_W'(x_r[TRIG_ITERATIONS]);
        end
        eqd_pkg::QUAD_1: begin
          sc.s <= eqd_pkg::TRIG_W'(x_r[TRIG_ITERATIONS]);
          sc.c <= eqd_pkg::TRIG_W'(-y_r[TRIG_ITERATIONS]);
        end
        eqd_pkg::QUAD_2: begin
          sc.s <= eqd_pkg::TRIG_W'(-y_r[TRIG_ITERATIONS]);
          sc.c <= eqd_pkg::TRIG_W'(-x_r[TRIG_ITERATIONS]);
        end
        default: begin
          sc.s <= eqd_pkg::TRIG_W'(-x_r[TRIG_ITERATIONS]);
          sc.c <= eqd_pkg::TRIG_W'(y_r[TRIG_ITERATIONS]);
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/eqd_combine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqd_combine
// Merges the three lanes: products of sines and cosines into the four
// quaternion components, then the sum of their squares.
// ----------------------------------------------------------------------------
module eqd_combine (
  input  logic                                    clk,
  input  logic                                    en,
  input  eqd_pkg::sincos_t                        scx,
  input  eqd_pkg::sincos_t                        scy,
  input  eqd_pkg::sincos_t                        scz,
  output logic signed [eqd_pkg::COMP_W-1:0]       comp [0:3],
  output logic [eqd_pkg::SUM_W-1:0]               sum
);

  localparam int CW = eqd_pkg::COMP_W;

  logic signed [63:0] p_sxcy, p_cxsy, p_cxcy, p_sxsy;
  logic signed [CW-1:0] sxcy, cxsy, cxcy, sxsy;
  logic signed [eqd_pkg::TRIG_W-1:0] sz1, cz1;
  logic signed [63:0] a_r [0:3];
  logic signed [63:0] b_r [0:3];
  logic signed [64:0] d [0:3];
  logic signed [CW-1:0] q3_r [0:3];
  logic [63:0] sq_r [0:3];
  logic signed [CW-1:0] q4_r [0:3];

  // The x and y lanes are multiplied first and rounded down to Q30, then
  // each pair product is multiplied by the z lane.
  always_comb begin
    p_sxcy = scx.s * scy.c;
    p_cxsy = scx.c * scy.s;
    p_cxcy = scx.c * scy.c;
    p_sxsy = scx.s * scy.s;
    d[0] = 65'(a_r[0]) - 65'(b_r[0]);
    d[1] = 65'(a_r[1]) + 65'(b_r[1]);
    d[2] = 65'(a_r[2]) - 65'(b_r[2]);
    d[3] = 65'(a_r[3]) + 65'(b_r[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sxcy <= CW'(p_sxcy >>> 30);
      cxsy <= CW'(p_cxsy >>> 30);
      cxcy <= CW'(p_cxcy >>> 30);
      sxsy <= CW'(p_sxsy >>> 30);
      sz1  <= scz.s;
      cz1  <= scz.c;

      a_r[0] <= sxcy * cz1;
      b_r[0] <= cxsy * sz1;
      a_r[1] <= cxsy * cz1;
      b_r[1] <= sxcy * sz1;
      a_r[2] <= cxcy * sz1;
      b_r[2] <= sxsy * cz1;
      a_r[3] <= cxcy * cz1;
      b_r[3] <= sxsy * sz1;

      for (int k = 0; k < 4; k++) begin
        q3_r[k] <= CW'(d[k] >>> 30);
        sq_r[k] <= 64'(q3_r[k]) * 64'(q3_r[k]);
        q4_r[k] <= q3_r[k];
        comp[k] <= q4_r[k];
      end
      sum <= sq_r[0] + sq_r[1] + sq_r[2] + sq_r[3];
    end
  end

endmodule

// File: hw/rtl/eqd_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqd_isqrt
// Pipelined integer square root of the 64-bit sum of squares, one result
// bit per stage, with the components carried alongside.
// ----------------------------------------------------------------------------
module eqd_isqrt (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [eqd_pkg::COMP_W-1:0]  comp_in [0:3],
  input  logic [eqd_pkg::SUM_W-1:0]          sum,
  output logic signed [eqd_pkg::COMP_W-1:0]  comp_out [0:3],
  output logic [eqd_pkg::NORM_W-1:0]         norm
);

  localparam int N = eqd_pkg::ISQRT_STAGES;

  logic [63:0] v_r   [0:N-1];
  logic [63:0] res_r [0:N-1];
  logic signed [eqd_pkg::COMP_W-1:0] c_r [0:N-1][0:3];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * i);
    logic [63:0] v_in, res_in, trial;
    logic signed [eqd_pkg::COMP_W-1:0] c_in [0:3];

    if (i == 0) begin : g_first
      assign v_in   = sum;
      assign res_in = '0;
      assign c_in   = comp_in;
    end else begin : g_next
      assign v_in   = v_r[i-1];
      assign res_in = res_r[i-1];
      assign c_in   = c_r[i-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        c_r[i] <= c_in;
        if (v_in >= trial) begin
          v_r[i]   <= v_in - trial;
          res_r[i] <= (res_in >> 1) + BIT;
        end else begin
          v_r[i]   <= v_in;
          res_r[i] <= res_in >> 1;
        end
      end
    end
  end

  assign comp_out = c_r[N-1];
  assign norm     = res_r[N-1][eqd_pkg::NORM_W-1:0];

endmodule

// File: hw/rtl/eqd_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqd_div_lane
// Scales one component by 2^OUT_FRAC_BITS / norm with round half away from
// zero and saturation, by restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module eqd_div_lane #(
  parameter int OUT_FRAC_BITS = eqd_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [eqd_pkg::COMP_W-1:0]  comp,
  input  logic [eqd_pkg::NORM_W-1:0]         norm,
  output logic [eqd_pkg::QUAT_W-1:0]         quat,
  output logic                               zero
);

  localparam int F  = OUT_FRAC_BITS;
  localparam int DW = F + 35;
  localparam int QW = F + 1;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << F;

  logic [eqd_pkg::COMP_W-1:0] mag;
  logic [DW-1:0]              num;

  logic [DW-1:0]              r_r   [0:F+1];
  logic [QW-1:0]              q_r   [0:F+1];
  logic [eqd_pkg::NORM_W-1:0] dvs_r [0:F+1];
  logic                       neg_r [0:F+1];
  logic                       sat_r [0:F+1];
  logic                       zero_r[0:F+1];

  logic [QW-1:0]              qv;
  logic signed [31:0]         res;

  always_comb begin
    mag = comp[eqd_pkg::COMP_W-1] ? eqd_pkg::COMP_W'(-comp) : comp;
    num = (DW'(mag) << F) + DW'(norm >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]    <= num;
      q_r[0]    <= '0;
      dvs_r[0]  <= norm;
      neg_r[0]  <= comp[eqd_pkg::COMP_W-1];
      // A quotient of 2^(F+1) or more saturates regardless of its low bits.
      sat_r[0]  <= num >= (DW'(norm) << (F + 1));
      zero_r[0] <= norm == '0;
    end
  end

  for (genvar j = 0; j <= F; j++) begin : g_bit
    localparam int B = F - j;
    logic [DW-1:0] shifted;
    assign shifted = DW'(dvs_r[j]) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        dvs_r[j+1]  <= dvs_r[j];
        neg_r[j+1]  <= neg_r[j];
        sat_r[j+1]  <= sat_r[j];
        zero_r[j+1] <= zero_r[j];
        if (r_r[j] >= shifted) begin
          r_r[j+1] <= r_r[j] - shifted;
          q_r[j+1] <= q_r[j] | (QW'(1) << B);
        end else begin
          r_r[j+1] <= r_r[j];
          q_r[j+1] <= q_r[j];
        end
      end
    end
  end

  always_comb begin
    qv  = (sat_r[F+1] || q_r[F+1] > ONE_Q) ? ONE_Q : q_r[F+1];
    res = neg_r[F+1] ? -$signed(32'(qv)) : $signed(32'(qv));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat <= res[eqd_pkg::QUAT_W-1:0];
      zero <= zero_r[F+1];
    end
  end

endmodule

// File: hw/rtl/eqd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqd_checker
// Port-level checks of the Euler to quaternion unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eqd_checker #(
  parameter int OUT_FRAC_BITS = eqd_pkg::OUT_FRAC_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [eqd_pkg::QUAT_W-1:0] quat_x,
  input logic signed [eqd_pkg::QUAT_W-1:0] quat_w
);

  localparam int ONE = 1 << OUT_FRAC_BITS;
  localparam bit WIDE = OUT_FRAC_BITS > 14;

  // No result can be left over from before reset.
  `EQD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

  // An empty output register never blocks the input side.
  `EQD_ASSERT(a_ready_when_empty, clk, rst, !out_valid |-> in_ready)

  // A waiting result stays put until taken.
  `EQD_ASSERT(a_hold_stalled, clk, rst,
      out_valid && !out_ready |=> out_valid && $stable(quat_x) && $stable(quat_w))

  // Outputs stay within +-one for OUT_FRAC_BITS <= 14; w only when in_valid.
  `EQD_ASSERT(a_range_x, clk, rst,
      out_valid |-> WIDE || (quat_x <= ONE && quat_x >= -ONE))
  `EQD_ASSERT(a_range_w, clk, rst,
      out_valid && in_valid |-> WIDE || (quat_w <= ONE && quat_w >= -ONE))

endmodule

bind euler_degrees_to_quaternion_unit eqd_checker #(
  .OUT_FRAC_BITS(OUT_FRAC_BITS)
) u_eqd_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(angles.valid),
  .in_ready(angles.ready),
  .out_valid(quat.valid),
  .out_ready(quat.ready),
  .quat_x(quat.quat_x),
  .quat_w(quat.quat_w)
);
